// ===== hw/rtl/svlc_pkg.sv =====
// ============================================================================
// svlc_pkg
// Shared types and constants for the supply-voltage load cutoff block.
// ============================================================================
package svlc_pkg;

    // Averaging: a power-of-two sample count, so the average is a shift.
    localparam int SAMPLES_PER_AVERAGE = 16;
    localparam int ADC_BITS            = 12;
    localparam int CODE_W              = 12;
    localparam int AVG_SHIFT           = $clog2(SAMPLES_PER_AVERAGE);
    localparam int SCNT_W              = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int ACC_W               = ADC_BITS + AVG_SHIFT;

    localparam int DELAY_W = 8;
    localparam int DISP_W  = 4;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_MIN_SUPPLY  = 3'd0;
    localparam logic [REG_W-1:0] REG_MAX_SUPPLY  = 3'd1;
    localparam logic [REG_W-1:0] REG_RESTORE     = 3'd2;
    localparam logic [REG_W-1:0] REG_DELAY_ON    = 3'd3;
    localparam logic [REG_W-1:0] REG_DISPLAY_ON  = 3'd4;

    localparam logic [CODE_W-1:0]  RST_MIN_SUPPLY = 12'd2882;
    localparam logic [CODE_W-1:0]  RST_MAX_SUPPLY = 12'd3637;
    localparam logic [CODE_W-1:0]  RST_RESTORE    = 12'd3385;
    localparam logic [DELAY_W-1:0] RST_DELAY_ON   = 8'd60;
    localparam logic [DISP_W-1:0]  RST_DISPLAY_ON = 4'd10;

    // Request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ADC_BITS-1:0] sample;
        logic              button;
    } t_request;

    typedef struct packed {
        logic              load_on;
        logic              display_on;
        logic              led_on;
        logic [CODE_W-1:0] average_code;
        logic              lockout;
    } t_result;

endpackage

// ===== hw/rtl/svlc_if.sv =====
// ============================================================================
// svlc_if
// Valid/ready channels for requests into and results out of the block.
// ============================================================================
interface svlc_in_if import svlc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [ADC_BITS-1:0] sample;
    logic                button;

    modport source (output valid, output opcode, output sample, output button, input ready);
    modport sink   (input valid, input opcode, input sample, input button, output ready);
endinterface

interface svlc_out_if import svlc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              load_on;
    logic              display_on;
    logic              led_on;
    logic [CODE_W-1:0] average_code;
    logic              lockout;

    modport source (output valid, output load_on, output display_on, output led_on,
                    output average_code, output lockout, input ready);
    modport sink   (input valid, input load_on, input display_on, input led_on,
                    input average_code, input lockout, output ready);
endinterface

// ===== hw/rtl/supply_voltage_load_cutoff.sv =====
// ============================================================================
// supply_voltage_load_cutoff
// Averages supply ADC samples and, on each tick request, decides whether
// the load may be connected; also runs the display timer and the LED.
// ============================================================================
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  i_in     | in  | valid/ready        | opcode, sample, button
//  o_out    | out | valid/ready        | load_on, display_on, led_on,
//           |     |                    | average_code, lockout
//  APB      | in  | psel/penable/pready| paddr, pwdata, pwrite -> prdata
//
//  One request per cycle sustained while the result queue has room; every
//  request yields one result. Path: accept -> input register -> compute and
//  state update -> result queue; the result shows on the output once it is
//  registered in the queue.
//  The two-entry result queue lets requests keep flowing while the sink
//  stalls, until the queue fills; the input stops only when the queue is full
//  and the input register holds a request.
//  Synchronous active-low reset clears all state but the held request and
//  queue entries; config registers take their default thresholds.
// ============================================================================
module supply_voltage_load_cutoff
    import svlc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    svlc_in_if.sink            i_in,
    svlc_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]  r_min_code;
    logic [CODE_W-1:0]  r_max_code;
    logic [CODE_W-1:0]  r_restore_code;
    logic [DELAY_W-1:0] r_delay_on;
    logic [DISP_W-1:0]  r_display_on;
    logic [REG_W-1:0]   reg_sel;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_code     <= RST_MIN_SUPPLY;
            r_max_code     <= RST_MAX_SUPPLY;
            r_restore_code <= RST_RESTORE;
            r_delay_on     <= RST_DELAY_ON;
            r_display_on   <= RST_DISPLAY_ON;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MIN_SUPPLY: begin
                    r_min_code <= pwdata[CODE_W-1:0];
                end
                REG_MAX_SUPPLY: begin
                    r_max_code <= pwdata[CODE_W-1:0];
                end
                REG_RESTORE: begin
                    r_restore_code <= pwdata[CODE_W-1:0];
                end
                REG_DELAY_ON: begin
                    r_delay_on <= pwdata[DELAY_W-1:0];
                end
                REG_DISPLAY_ON: begin
                    r_display_on <= pwdata[DISP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Readback, zero-extended; unmapped addresses read zero
    always_comb begin
        case (reg_sel)
            REG_MIN_SUPPLY: prdata = PDATA_W'(r_min_code);
            REG_MAX_SUPPLY: prdata = PDATA_W'(r_max_code);
            REG_RESTORE:    prdata = PDATA_W'(r_restore_code);
            REG_DELAY_ON:   prdata = PDATA_W'(r_delay_on);
            REG_DISPLAY_ON: prdata = PDATA_W'(r_display_on);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic     r_s1_valid;
    t_request r_s1;
    logic     fire;       // compute stage consumes the held request
    logic     q_room;
    logic     in_take;

    assign i_in.ready = !r_s1_valid || fire;
    assign in_take    = i_in.valid && i_in.ready;
    assign fire       = r_s1_valid && q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.opcode <= i_in.opcode;
            r_s1.sample <= i_in.sample;
            r_s1.button <= i_in.button;
        end
    end

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]   r_acc,   n_acc;
    logic [SCNT_W-1:0]  r_scnt,  n_scnt;
    logic [CODE_W-1:0]  r_avg,   n_avg;
    logic               r_load,  n_load;
    logic               r_latch, n_latch;
    logic [DELAY_W-1:0] r_dcnt,  n_dcnt;
    logic [DISP_W-1:0]  r_disp_cnt, n_disp_cnt;
    logic               r_led,   n_led;
    logic               r_disp,  n_disp;

    logic              want_on;
    logic              hold;
    logic              too_low;
    logic              good;
    logic [DISP_W-1:0] disp_base;

    always_comb begin
        n_acc      = r_acc;
        n_scnt     = r_scnt;
        n_avg      = r_avg;
        n_load     = r_load;
        n_latch    = r_latch;
        n_dcnt     = r_dcnt;
        n_disp_cnt = r_disp_cnt;
        n_led      = r_led;
        n_disp     = r_disp;
        want_on    = 1'b0;
        hold       = r_latch && (r_avg < r_restore_code);
        too_low    = (r_avg <= r_min_code);
        good       = !too_low && (r_avg < r_max_code);
        disp_base  = r_s1.button ? '0 : r_disp_cnt;

        if (r_s1.opcode == OP_SAMPLE) begin
            // Accumulate until full; the next sample closes the window
            if (r_scnt < SCNT_W'(SAMPLES_PER_AVERAGE)) begin
                n_acc  = r_acc + ACC_W'(r_s1.sample);
                n_scnt = r_scnt + 1'b1;
            end else begin
                n_avg  = CODE_W'(r_acc >> AVG_SHIFT);
                n_acc  = '0;
                n_scnt = '0;
            end
        end else begin
            // On-delay counts only while the load is off
            if (!r_load) begin
                if (r_dcnt < r_delay_on) begin
                    n_dcnt = r_dcnt + 1'b1;
                end else begin
                    want_on = 1'b1;
                end
            end
            // Lockout hold skips the window check entirely
            if (!hold) begin
                if (good) begin
                    if (want_on) begin
                        n_load  = 1'b1;
                        n_latch = 1'b0;
                    end
                end else begin
                    if (too_low) begin
                        n_latch = 1'b1;
                    end
                    n_load = 1'b0;
                    n_dcnt = '0;
                end
            end
            // Display timer, restarted by the button
            if (disp_base < r_display_on) begin
                n_disp_cnt = disp_base + 1'b1;
                n_disp     = 1'b1;
            end else begin
                n_disp_cnt = disp_base;
                n_disp     = 1'b0;
            end
            n_led = n_load ? 1'b1 : !r_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_scnt     <= '0;
            r_avg      <= '0;
            r_load     <= 1'b0;
            r_latch    <= 1'b0;
            r_dcnt     <= '0;
            r_disp_cnt <= '0;
            r_led      <= 1'b0;
            r_disp     <= 1'b0;
        end else if (fire) begin
            r_acc      <= n_acc;
            r_scnt     <= n_scnt;
            r_avg      <= n_avg;
            r_load     <= n_load;
            r_latch    <= n_latch;
            r_dcnt     <= n_dcnt;
            r_disp_cnt <= n_disp_cnt;
            r_led      <= n_led;
            r_disp     <= n_disp;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry result queue
    // ------------------------------------------------------------------
    t_result     r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic        pop;
    t_result     res;

    assign res.load_on      = n_load;
    assign res.display_on   = n_disp;
    assign res.led_on       = n_led;
    assign res.average_code = n_avg;
    assign res.lockout      = n_latch;

    assign pop    = o_out.valid && o_out.ready;
    assign q_room = (r_cnt != 2'd2) || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (fire) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, fire} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_q[r_wptr] <= res;
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.load_on      = r_q[r_rptr].load_on;
    assign o_out.display_on   = r_q[r_rptr].display_on;
    assign o_out.led_on       = r_q[r_rptr].led_on;
    assign o_out.average_code = r_q[r_rptr].average_code;
    assign o_out.lockout      = r_q[r_rptr].lockout;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overfilled");

    a_load_vs_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_load && r_latch))
        else $error("load on while lockout latched");

    a_led_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |-> r_led)
        else $error("LED not steady while load on");

    a_sample_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scnt <= SCNT_W'(SAMPLES_PER_AVERAGE))
        else $error("sample count past averaging window");

    a_push_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("result lost on push");
`endif

endmodule
